// ----- rtl/gps_time_to_calendar_date_top_macros.svh -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GPS_TIME_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define GPS_TIME_TO_CALENDAR_DATE_TOP_MACROS_SVH

// Same-cycle implication
`define GTCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GTCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gtcd_pkg.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: package
// Shared types, constants and lookup tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtcd_pkg;

  localparam int FRAC_BITS = 20;
  localparam logic [19:0] FRAC_MASK =
    (FRAC_BITS >= 20) ? 20'hFFFFF : 20'((64'd1 << FRAC_BITS) - 64'd1);

  localparam int Q_DEPTH_DEFAULT = 2;

  localparam int SECS_PER_DAY = 86400;
  localparam logic [19:0] SECS_PER_WEEK = 20'd604800;

  // First second of each weekday within the week
  localparam logic [19:0] DAY_START [8] = '{
    20'd0, 20'd86400, 20'd172800, 20'd259200,
    20'd345600, 20'd432000, 20'd518400, 20'd0
  };

  // Smallest day count reaching month index k: ceil(30.6001 * k)
  localparam logic [8:0] F_THR [16] = '{
    9'd0, 9'd31, 9'd62, 9'd92, 9'd123, 9'd154, 9'd184, 9'd215,
    9'd245, 9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
  };

  // floor(30.6001 * f)
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  typedef struct packed {
    logic signed [16:0] days;   // whole days since the GPS epoch
    logic [16:0]        sod;    // second of day
    logic [2:0]         dow;
    logic [19:0]        frac;
  } front_item_t;

endpackage

// ----- rtl/gtcd_in_if.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: input channel
// Valid/ready channel carrying one GPS time stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gtcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] gps_week;
  logic [19:0]        whole_seconds;
  logic [19:0]        frac_seconds;

  modport source (output valid, output gps_week, output whole_seconds,
                  output frac_seconds, input ready);
  modport sink (input valid, input gps_week, input whole_seconds,
                input frac_seconds, output ready);
endinterface

// ----- rtl/gtcd_out_if.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: output channel
// Valid/ready channel carrying one calendar date and time of day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gtcd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [19:0] second_fraction;
  logic [2:0]  weekday;
  logic [8:0]  year_day;
  logic [16:0] modified_julian_day;
  logic        in_range;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour_of_day, output minute_of_hour,
                  output second_of_minute, output second_fraction,
                  output weekday, output year_day, output modified_julian_day,
                  output in_range, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour_of_day, input minute_of_hour,
                input second_of_minute, input second_fraction,
                input weekday, input year_day, input modified_julian_day,
                input in_range, output ready);
endinterface

// ----- rtl/gps_time_to_calendar_date_top.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: top level
// Path: a time stamp passes the front register, the queue and the back end.
// Throughput: one item per cycle while result is ready (pipelined back end).
// Reset: synchronous, active high; empties front register, queue and pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_time_to_calendar_date_top import gtcd_pkg::*; #(
  parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  gtcd_in_if.sink    sample,
  gtcd_out_if.source result
);

  logic        push_valid;
  logic        push_ready;
  front_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  front_item_t pop_item;

  gtcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  gtcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  gtcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .result    (result)
  );

endmodule

// ----- rtl/gtcd_front.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: front end
// Accepts a time stamp, folds overflow seconds into the week, splits the
// time of week into weekday and second of day, and counts days from epoch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtcd_front import gtcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gtcd_in_if.sink     sample,
  output logic        push_valid,
  input  logic        push_ready,
  output front_item_t push_item
);

  logic               fv;
  front_item_t        item;
  front_item_t        item_next;
  logic               over;
  logic [19:0]        secs;
  logic [5:0]         day_hit;
  logic [2:0]         dow;
  logic signed [17:0] week_ext;
  logic signed [17:0] days_calc;

  always_comb begin
    over = sample.whole_seconds >= SECS_PER_WEEK;
    secs = over ? sample.whole_seconds - SECS_PER_WEEK : sample.whole_seconds;
    for (int k = 1; k < 7; k++) begin
      day_hit[k-1] = secs >= 20'(k * SECS_PER_DAY);
    end
    dow = 3'($countones(day_hit));
    week_ext = 18'(sample.gps_week) + $signed({17'd0, over});
    days_calc = (week_ext <<< 3) - week_ext + $signed({15'd0, dow});
    item_next.days = days_calc[16:0];
    item_next.sod = 17'(secs - DAY_START[dow]);
    item_next.dow = dow;
    item_next.frac = sample.frac_seconds & FRAC_MASK;
  end

  assign sample.ready = !fv || push_ready;
  assign push_valid = fv;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item <= item_next;
    end
  end

endmodule

// ----- rtl/gtcd_queue.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: decoupling queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtcd_queue import gtcd_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  front_item_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output front_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  front_item_t   entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_item = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/gtcd_back.sv -----
// ----------------------------------------------------------------------------
// GPS time to calendar date: back end
// Seven-stage pipeline: Julian day to year/month/day, day of year, time of
// day, MJD and span check. Divisions by constants use reciprocal products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gps_time_to_calendar_date_top_macros.svh"

module gtcd_back import gtcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  front_item_t pop_item,
  gtcd_out_if.source  result
);

  typedef struct packed {
    logic signed [16:0] days;
    logic [16:0]        sod;
    logic [2:0]         dow;
    logic [19:0]        frac;
    logic [16:0]        mjd;
    logic               in_range;
    logic [21:0]        n;      // 20c - 2442, less 6538 periods of 7305
    logic [16:0]        dyp;    // days from 1904 Jan 1, plus 24 quad years
    logic [31:0]        ph;
    logic [43:0]        pq;
    logic [38:0]        py;
    logic [4:0]         hour;
    logic [11:0]        rem;
    logic [23:0]        pm;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [12:0]        d;
    logic [8:0]         yy;
    logic [21:0]        e;
    logic [18:0]        fy;
    logic [8:0]         g;
    logic [8:0]         doy;
    logic [3:0]         f;
  } stage_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] frac;
    logic [2:0]  dow;
    logic [8:0]  doy;
    logic [16:0] mjd;
    logic        in_range;
  } res_t;

  logic [6:0] vld;
  logic       adv;
  stage_t     st1, st2, st3, st4, st5, st6;
  stage_t     st1_next, st2_next, st3_next, st4_next, st5_next, st6_next;
  res_t       res, res_next;

  logic signed [22:0] n_calc;
  logic signed [18:0] dyp_calc;
  logic signed [18:0] mjd_calc;
  logic [16:0]        hsec;
  logic [11:0]        msec;
  logic signed [22:0] c_calc;
  logic               leap;
  logic [14:0]        thr_hit;

  // Whole pipeline moves when the result register is free or being taken
  assign adv = !vld[6] || result.ready;
  assign pop_ready = adv;

  // Stage 1: offsets, MJD, span check, hour product
  always_comb begin
    st1_next = '0;
    st1_next.days = pop_item.days;
    st1_next.sod = pop_item.sod;
    st1_next.dow = pop_item.dow;
    st1_next.frac = pop_item.frac;
    n_calc = (23'(pop_item.days) <<< 4) + (23'(pop_item.days) <<< 2) + 23'sd1153108;
    st1_next.n = n_calc[21:0];
    dyp_calc = 19'(pop_item.days) + 19'sd62828;
    st1_next.dyp = dyp_calc[16:0];
    mjd_calc = 19'(pop_item.days) + 19'sd44244;
    st1_next.mjd = mjd_calc[16:0];
    st1_next.in_range = (mjd_calc >= 19'sd15444) && (mjd_calc <= 19'sd88127);
    st1_next.ph = {15'd0, pop_item.sod} * 32'd37283;
  end

  // Stage 2: century and quad-year products, hour and remainder
  always_comb begin
    st2_next = st1;
    st2_next.pq = {22'd0, st1.n} * 44'd2351796;
    st2_next.py = {20'd0, st1.dyp, 2'b00} * 39'd734937;
    st2_next.hour = st1.ph[31:27];
    hsec = {12'd0, st1.ph[31:27]} * 17'd3600;
    st2_next.rem = 12'(st1.sod - hsec);
  end

  // Stage 3: year counts, minute product
  always_comb begin
    st3_next = st2;
    st3_next.d = {4'd0, st2.pq[42:34]} + 13'd6538;
    st3_next.yy = st2.py[38:30];
    st3_next.pm = {12'd0, st2.rem} * 24'd4370;
  end

  // Stage 4: day counts of whole years, minute and second
  always_comb begin
    st4_next = st3;
    st4_next.e = ({9'd0, st3.d} * 22'd365) + {11'd0, st3.d[12:2]};
    st4_next.fy = {10'd0, st3.yy} * 19'd1461;
    st4_next.minute = st3.pm[23:18];
    msec = {6'd0, st3.pm[23:18]} * 12'd60;
    st4_next.second = 6'(st3.rem - msec);
  end

  // Stage 5: day within the March-based year, day of year
  always_comb begin
    st5_next = st4;
    c_calc = 23'(st4.days) + 23'sd2445782;
    st5_next.g = 9'(c_calc[21:0] - st4.e);
    leap = st4.yy[1:0] == 2'd0;
    st5_next.doy = 9'(st4.dyp - st4.fy[18:2] + {16'd0, leap});
  end

  // Stage 6: month index by threshold count
  always_comb begin
    st6_next = st5;
    for (int k = 1; k < 16; k++) begin
      thr_hit[k-1] = st5.g >= F_THR[k];
    end
    st6_next.f = 4'($countones(thr_hit));
  end

  // Stage 7: calendar fields into the result register
  always_comb begin
    res_next.day = 5'(st6.g - CUM_DAYS[st6.f]);
    res_next.month = (st6.f >= 4'd14) ? st6.f - 4'd13 : st6.f - 4'd1;
    res_next.year = 12'(st6.d - 13'd4715 - {12'd0, (st6.f < 4'd14)});
    res_next.hour = st6.hour;
    res_next.minute = st6.minute;
    res_next.second = st6.second;
    res_next.frac = st6.frac;
    res_next.dow = st6.dow;
    res_next.doy = st6.doy;
    res_next.mjd = st6.mjd;
    res_next.in_range = st6.in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1 <= st1_next;
      st2 <= st2_next;
      st3 <= st3_next;
      st4 <= st4_next;
      st5 <= st5_next;
      st6 <= st6_next;
      res <= res_next;
    end
  end

  assign result.valid = vld[6];
  assign result.year = res.year;
  assign result.month = res.month;
  assign result.day_of_month = res.day;
  assign result.hour_of_day = res.hour;
  assign result.minute_of_hour = res.minute;
  assign result.second_of_minute = res.second;
  assign result.second_fraction = res.frac;
  assign result.weekday = res.dow;
  assign result.year_day = res.doy;
  assign result.modified_julian_day = res.mjd;
  assign result.in_range = res.in_range;

  `GTCD_ASSERT_IMPL(a_time_fields, vld[3],
    (st4.hour <= 5'd23) && (st4.minute <= 6'd59) && (st4.second <= 6'd59),
    "time of day field out of range")
  `GTCD_ASSERT_IMPL(a_march_day, vld[4], (st5.g >= 9'd123) && (st5.g <= 9'd488),
    "day within March-based year out of range")
  `GTCD_ASSERT_IMPL(a_valid_date, vld[6] && res.in_range,
    (res.month >= 4'd1) && (res.month <= 4'd12) && (res.day >= 5'd1) &&
    (res.day <= 5'd31) && (res.doy >= 9'd1) && (res.doy <= 9'd366),
    "date field out of range inside valid span")
  `GTCD_ASSERT_NEXT(a_stall_keeps, !adv, vld == $past(vld),
    "pipeline occupancy changed while stalled")

endmodule

// ----- tb/gps_time_to_calendar_date_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS time to calendar date: testbench
// Sends GPS week / time-of-week stamps through the valid/ready input channel
// and checks every calendar result, field by field and in order, against an
// integer Julian-day conversion computed here. Both channels idle at random.
// ----------------------------------------------------------------------------

module gps_time_to_calendar_date_top_tb;
  import gtcd_pkg::*;

  localparam int  HALF_PERIOD     = 4;
  localparam int  RESET_CYCLES    = 7;
  localparam int  RANDOM_STAMPS   = 1200;
  localparam int  SETTLE_CYCLES   = 16;
  localparam int  CYCLE_LIMIT     = 200000;
  localparam int  MAX_REPORTS     = 10;

  localparam longint WEEK_SECS       = 604800;
  localparam longint DAY_SECS        = 86400;
  localparam longint EPOCH_MJD       = 44244;
  localparam longint EPOCH_JD_SHIFT  = 2444245 + 1537;
  localparam longint MJD_1904        = 16480;
  localparam longint MJD_FIRST_VALID = 15444;
  localparam longint MJD_LAST_VALID  = 88127;
  localparam longint LEAP_CYCLE_DAYS = 1461;

  typedef struct {
    logic [13:0] week;
    logic [19:0] secs;
    logic [19:0] frac;
    bit          drain;  // hold this item until all results are back
    int unsigned gap;    // idle cycles before this item
  } stamp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [19:0] second_fraction;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
    logic [16:0] modified_julian_day;
    logic        in_range;
  } cal_date_t;

  logic clk = 1'b0;
  logic rst;

  gtcd_in_if  sample_if ();
  gtcd_out_if result_if ();

  gps_time_to_calendar_date_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if)
  );

  stamp_t      stamp_q[$];
  cal_date_t   dates_due[$];
  bit          tx_calm;
  bit          in_took;
  bit          out_took;
  int unsigned tx_wait;
  int unsigned rx_stall;
  int unsigned n_results;
  int unsigned mismatches;
  int unsigned cycles;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic cal_date_t convert_gps_time(logic signed [13:0] week_in,
                                                 logic [19:0] secs_in,
                                                 logic [19:0] frac_in);
    longint week, secs, dow, days, mjd, c, d, e, f, dom, mon, yr, dy, yy, doy;
    cal_date_t r;
    week = week_in;
    secs = secs_in;
    // a time-of-week past the end of the week rolls into the next week
    if (secs >= WEEK_SECS) begin
      secs -= WEEK_SECS;
      week += 1;
    end
    dow  = secs / DAY_SECS;
    days = 7 * week + dow;
    mjd  = EPOCH_MJD + days;

    c   = days + EPOCH_JD_SHIFT;
    d   = floor_quot(100 * c - 12210, 36525);
    e   = 365 * d + floor_quot(d, 4);
    f   = floor_quot(10000 * (c - e), 306001);
    dom = c - e - floor_quot(306001 * f, 10000);
    mon = f - 1 - 12 * floor_quot(f, 14);
    yr  = d - 4715 - floor_quot(7 + mon, 10);

    // day of year from the leap cycle starting 1904 Jan 1
    dy  = mjd - MJD_1904;
    yy  = floor_quot(4 * dy, LEAP_CYCLE_DAYS);
    doy = dy - floor_quot(LEAP_CYCLE_DAYS * yy, 4);
    if (yy - 4 * floor_quot(yy, 4) == 0) doy += 1;

    r.year                = 12'(yr);
    r.month               = 4'(mon);
    r.day_of_month        = 5'(dom);
    r.hour_of_day         = 5'((secs / 3600) % 24);
    r.minute_of_hour      = 6'((secs / 60) % 60);
    r.second_of_minute    = 6'(secs % 60);
    r.second_fraction     = frac_in & FRAC_MASK;
    r.weekday             = 3'(dow);
    r.year_day            = 9'(doy);
    r.modified_julian_day = 17'(mjd);
    r.in_range            = (mjd >= MJD_FIRST_VALID && mjd <= MJD_LAST_VALID);
    return r;
  endfunction

  task automatic add_stamp(logic [13:0] week, logic [19:0] secs, logic [19:0] frac,
                           bit drain);
    stamp_t s;
    s.week  = week;
    s.secs  = secs;
    s.frac  = frac;
    s.drain = drain;
    s.gap   = tx_calm ? 0 : $urandom_range(7);
    stamp_q.push_back(s);
  endtask

  // Build a stamp that lands on a given MJD at a given second of the day
  task automatic add_date_stamp(longint mjd, longint sod, bit drain);
    longint days, week;
    days = mjd - EPOCH_MJD;
    week = floor_quot(days, 7);
    add_stamp(14'(week), 20'((days - 7 * week) * DAY_SECS + sod), 20'($urandom), drain);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", n_results, name, want, got);
    end
  endtask

  // Sender: present one stamp at a time, idling per item
  always @(negedge clk) begin
    stamp_t next_stamp;
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || in_took) begin
      if (tx_wait > 0) begin
        sample_if.valid <= 1'b0;
        tx_wait--;
      end else if (stamp_q.size() == 0 || (stamp_q[0].drain && dates_due.size() != 0)) begin
        sample_if.valid <= 1'b0;
      end else begin
        next_stamp = stamp_q.pop_front();
        sample_if.valid         <= 1'b1;
        sample_if.gps_week      <= next_stamp.week;
        sample_if.whole_seconds <= next_stamp.secs;
        sample_if.frac_seconds  <= next_stamp.frac;
        tx_wait = (stamp_q.size() != 0) ? stamp_q[0].gap : 0;
      end
    end
  end

  // Receiver: stall a random number of cycles after each result, with calm stretches
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (out_took) rx_stall = (((n_results / 128) % 4) == 2) ? 0 : $urandom_range(7);
      if (rx_stall > 0) begin
        result_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Check results against the oldest expectation, then record new stamps
  always @(posedge clk) begin
    cal_date_t want;
    in_took  = 1'b0;
    out_took = 1'b0;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        out_took = 1'b1;
        if (dates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: arrived with no stamp outstanding", n_results);
        end else begin
          want = dates_due.pop_front();
          check_field("year", want.year, result_if.year);
          check_field("month", want.month, result_if.month);
          check_field("day_of_month", want.day_of_month, result_if.day_of_month);
          check_field("hour_of_day", want.hour_of_day, result_if.hour_of_day);
          check_field("minute_of_hour", want.minute_of_hour, result_if.minute_of_hour);
          check_field("second_of_minute", want.second_of_minute, result_if.second_of_minute);
          check_field("second_fraction", want.second_fraction, result_if.second_fraction);
          check_field("weekday", want.weekday, result_if.weekday);
          check_field("year_day", want.year_day, result_if.year_day);
          check_field("modified_julian_day", want.modified_julian_day,
                      result_if.modified_julian_day);
          check_field("in_range", want.in_range, result_if.in_range);
        end
        n_results++;
      end
      if (sample_if.valid && sample_if.ready) begin
        in_took = 1'b1;
        dates_due.push_back(convert_gps_time(sample_if.gps_week, sample_if.whole_seconds,
                                             sample_if.frac_seconds));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gps_time_to_calendar_date_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    bit          drain;
    longint      base;
    rst                     = 1'b1;
    sample_if.valid         = 1'b0;
    sample_if.gps_week      = '0;
    sample_if.whole_seconds = '0;
    sample_if.frac_seconds  = '0;
    result_if.ready         = 1'b0;
    tx_calm    = 1'b0;
    in_took    = 1'b0;
    out_took   = 1'b0;
    tx_wait    = 0;
    rx_stall   = 0;
    n_results  = 0;
    mismatches = 0;
    cycles     = 0;

    // directed: field extremes, week rollover, span edges, leap days
    add_stamp(14'sd0, 20'd0, 20'h00000, 1'b0);
    add_stamp(-14'sd1, 20'd604799, 20'hFFFFF, 1'b0);
    add_stamp(-14'sd8192, 20'd0, 20'h00000, 1'b0);
    add_stamp(14'sd8191, 20'hFFFFF, 20'hFFFFF, 1'b0);
    add_stamp(14'sd8191, 20'd604800, 20'h00000, 1'b0);
    add_stamp(-14'sd8192, 20'hFFFFF, 20'h55555, 1'b0);
    add_stamp(14'sd0, 20'd604800, 20'h00001, 1'b0);
    add_stamp(-14'sd4200, 20'd0, 20'h80000, 1'b0);
    add_stamp(14'sd6300, 20'd604799, 20'h7FFFF, 1'b0);
    add_stamp(14'sd0, 20'd86399, 20'hAAAAA, 1'b0);
    add_stamp(14'sd0, 20'd86400, 20'h12345, 1'b0);
    add_date_stamp(MJD_FIRST_VALID - 1, DAY_SECS - 1, 1'b0);
    add_date_stamp(MJD_FIRST_VALID, 0, 1'b1);
    add_date_stamp(MJD_LAST_VALID, DAY_SECS - 1, 1'b0);
    add_date_stamp(MJD_LAST_VALID + 1, 0, 1'b0);
    add_date_stamp(51603, 43200, 1'b0);           // 2000 Feb 29
    add_date_stamp(51909, 3599, 1'b0);            // 2000 Dec 31, day 366
    add_date_stamp(51910, 0, 1'b0);               // 2001 Jan 1
    add_date_stamp(MJD_1904, 0, 1'b0);
    add_date_stamp(MJD_1904 - 1, DAY_SECS - 1, 1'b0);

    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      tx_calm = (((i / 100) % 4) == 1);
      drain   = ((i % 300) == 150);
      pick    = $urandom_range(99);
      if (pick < 65) begin
        add_stamp(14'(-4200 + int'($urandom_range(10500))), 20'($urandom_range(604799)),
                  20'($urandom), drain);
      end else if (pick < 75) begin
        add_stamp(14'(-4200 + int'($urandom_range(10500))),
                  20'($urandom_range(20'hFFFFF, 604800)), 20'($urandom), drain);
      end else if (pick < 87) begin
        add_stamp(14'($urandom), 20'($urandom), 20'($urandom), drain);
      end else if (pick < 94) begin
        base = pick[0] ? MJD_FIRST_VALID : MJD_LAST_VALID;
        add_date_stamp(base + int'($urandom_range(40)) - 20, $urandom_range(86399), drain);
      end else begin
        // around Jan 1, Feb 29 or Dec 31 of a leap year
        base = MJD_1904 + LEAP_CYCLE_DAYS * int'($urandom_range(48));
        case ($urandom_range(2))
          0: base += 0;
          1: base += 59;
          default: base += 365;
        endcase
        add_date_stamp(base + int'($urandom_range(6)) - 3, $urandom_range(86399), drain);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stamp_q.size() != 0 || sample_if.valid) @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && dates_due.size() == 0) begin
      $display("gps_time_to_calendar_date_top_tb: PASS");
    end else begin
      $display("gps_time_to_calendar_date_top_tb: FAIL");
    end
    $finish;
  end

endmodule
